// File: src/alpha_mask_levels_compositor_macros.svh
// Assertion macros used by the checker file of the alpha-mask levels compositor.
`ifndef ALPHA_MASK_LEVELS_COMPOSITOR_MACROS_SVH
`define ALPHA_MASK_LEVELS_COMPOSITOR_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off during reset.
`define AMLC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and switched off during reset.
`define AMLC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/amlc_pkg.sv
// Types and constants of the alpha-mask levels compositor.
package amlc_pkg;

	// Configuration port sizes and register indexes.
	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 8;

	localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_SOURCE = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SKIP_LEVELS  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_MODE  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_LEVELS_BLACK = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_LEVELS_WHITE = 3'd4;

	// Output modes; the unused code behaves as pass-through.
	typedef enum logic [1:0] {
		MODE_PASS  = 2'd0,
		MODE_MERGE = 2'd1,
		MODE_MASK  = 2'd2
	} out_mode_t;

	// Reset values of the configuration registers.
	localparam logic      RST_ALPHA_SOURCE = 1'b0;
	localparam logic      RST_SKIP_LEVELS  = 1'b0;
	localparam out_mode_t RST_OUTPUT_MODE  = MODE_MERGE;
	localparam logic [7:0] RST_LEVELS_BLACK = 8'd0;
	localparam logic [7:0] RST_LEVELS_WHITE = 8'd210;

	// Full-scale byte value.
	localparam logic [7:0] BYTE_MAX = 8'hFF;

	// Configuration register set.
	typedef struct packed {
		logic       alpha_source;
		logic       skip_levels;
		out_mode_t  output_mode;
		logic [7:0] levels_black;
		logic [7:0] levels_white;
	} cfg_t;

	// Input request: main BGRA pixel and auxiliary BGR pixel.
	typedef struct packed {
		logic [7:0] main_blue;
		logic [7:0] main_green;
		logic [7:0] main_red;
		logic [7:0] main_alpha;
		logic [7:0] aux_blue;
		logic [7:0] aux_green;
		logic [7:0] aux_red;
	} pix_in_t;

	// Output request: result BGRA pixel.
	typedef struct packed {
		logic [7:0] out_blue;
		logic [7:0] out_green;
		logic [7:0] out_red;
		logic [7:0] out_alpha;
	} pix_out_t;

endpackage

// File: src/alpha_mask_levels_compositor.sv
// Top level of the alpha-mask levels compositor: mask build, levels remap and output select.
// An accepted request passes stage registers s1 to s6 in order; s6 drives the result on dst.
// Throughput: one pixel per cycle unless dst stalls; the remap divider is split two quotient
// bits per stage over four pipeline stages, so every stage takes a new pixel each cycle.
// A stall on dst holds the pipeline; empty stages still fill, and src stalls only when full.
// Reset clears all stage valid bits and loads the configuration reset values.
module alpha_mask_levels_compositor
	import amlc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wen,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   src_valid,
	output logic                   src_stall,
	input  pix_in_t                src_data,
	output logic                   dst_valid,
	input  logic                   dst_stall,
	output pix_out_t               dst_data
);

	// Divider state carried down the pipeline.
	typedef struct packed {
		logic [16:0] rem;
		logic [8:0]  den;
		logic [7:0]  quo;
		logic [7:0]  mask;
		logic        lo;
		logic        hi;
	} div_t;

	// Two restoring division steps, producing quotient bits msb and msb-1.
	function automatic div_t div_pair(div_t d, logic [2:0] msb);
		div_t        r;
		logic [16:0] trial;
		logic [2:0]  idx;
		r = d;
		for (int k = 0; k < 2; k++) begin
			idx   = msb - 3'(k);
			trial = {8'd0, r.den} << idx;
			if (r.rem >= trial) begin
				r.rem      = r.rem - trial;
				r.quo[idx] = 1'b1;
			end
		end
		return r;
	endfunction

	cfg_t     cfg_q;
	logic     v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic     en_s1, en_s2, en_s3, en_s4, en_s5, en_s6;
	pix_in_t  pix_s1, pix_s2, pix_s3, pix_s4, pix_s5;
	logic [7:0] mask_s1;
	div_t     div_s2, div_s3, div_s4, div_s5;
	pix_out_t out_s6;

	logic [7:0] mask_raw;
	logic [8:0] black9, white_eff;
	logic [7:0] range8, diff8;
	logic [16:0] num17;
	div_t     div_init, div_last;
	logic [7:0] mask_fin;
	pix_out_t out_next;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alpha_source <= RST_ALPHA_SOURCE;
			cfg_q.skip_levels  <= RST_SKIP_LEVELS;
			cfg_q.output_mode  <= RST_OUTPUT_MODE;
			cfg_q.levels_black <= RST_LEVELS_BLACK;
			cfg_q.levels_white <= RST_LEVELS_WHITE;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_ALPHA_SOURCE: cfg_q.alpha_source <= cfg_data[0];
				REG_SKIP_LEVELS:  cfg_q.skip_levels  <= cfg_data[0];
				REG_OUTPUT_MODE:  cfg_q.output_mode  <= out_mode_t'(cfg_data[1:0]);
				REG_LEVELS_BLACK: cfg_q.levels_black <= cfg_data;
				REG_LEVELS_WHITE: cfg_q.levels_white <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Stage enables: a stage moves when it is empty or the next one moves.
	assign en_s6     = !v_s6 || !dst_stall;
	assign en_s5     = !v_s5 || en_s6;
	assign en_s4     = !v_s4 || en_s5;
	assign en_s3     = !v_s3 || en_s4;
	assign en_s2     = !v_s2 || en_s3;
	assign en_s1     = !v_s1 || en_s2;
	assign src_stall = !en_s1;

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= src_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
			if (en_s4) begin
				v_s4 <= v_s3;
			end
			if (en_s5) begin
				v_s5 <= v_s4;
			end
			if (en_s6) begin
				v_s6 <= v_s5;
			end
		end
	end

	// Stage 1 logic: raw mask from the auxiliary pixel.
	always_comb begin
		if (src_data.aux_blue == 8'd0 && src_data.aux_green == 8'd0
				&& src_data.aux_red == 8'd0) begin
			mask_raw = 8'd0;
		end else begin
			mask_raw = BYTE_MAX;
		end
		if (cfg_q.alpha_source) begin
			mask_raw = src_data.aux_blue;
		end
	end

	// Stage 2 logic: clamp flags and the doubled-scale numerator and divisor.
	always_comb begin
		black9    = {1'b0, cfg_q.levels_black};
		white_eff = {1'b0, cfg_q.levels_white};
		if (white_eff < black9 + 9'd1) begin
			white_eff = black9 + 9'd1;
		end
		range8 = 8'(white_eff - black9);
		diff8  = mask_s1 - cfg_q.levels_black;
		num17  = ({9'd0, diff8} << 9) - ({9'd0, diff8} << 1) + {9'd0, range8};
		div_init.rem  = num17;
		div_init.den  = {range8, 1'b0};
		div_init.quo  = 8'd0;
		div_init.mask = mask_s1;
		div_init.lo   = (mask_s1 <= cfg_q.levels_black);
		div_init.hi   = ({1'b0, mask_s1} >= white_eff);
	end

	// Last stage logic: final quotient bits, clamp and output select.
	always_comb begin
		div_last = div_pair(div_s5, 3'd1);
		if (cfg_q.skip_levels) begin
			mask_fin = div_last.mask;
		end else if (div_last.lo) begin
			mask_fin = 8'd0;
		end else if (div_last.hi) begin
			mask_fin = BYTE_MAX;
		end else begin
			mask_fin = div_last.quo;
		end
		case (cfg_q.output_mode)
			MODE_MERGE: begin
				out_next.out_blue  = pix_s5.main_blue;
				out_next.out_green = pix_s5.main_green;
				out_next.out_red   = pix_s5.main_red;
				out_next.out_alpha = mask_fin;
			end
			MODE_MASK: begin
				out_next.out_blue  = mask_fin;
				out_next.out_green = mask_fin;
				out_next.out_red   = mask_fin;
				out_next.out_alpha = BYTE_MAX;
			end
			default: begin
				out_next.out_blue  = pix_s5.main_blue;
				out_next.out_green = pix_s5.main_green;
				out_next.out_red   = pix_s5.main_red;
				out_next.out_alpha = pix_s5.main_alpha;
			end
		endcase
	end

	// Pipeline payload registers.
	always_ff @(posedge clk) begin
		if (en_s1 && src_valid) begin
			pix_s1  <= src_data;
			mask_s1 <= mask_raw;
		end
		if (en_s2 && v_s1) begin
			pix_s2 <= pix_s1;
			div_s2 <= div_init;
		end
		if (en_s3 && v_s2) begin
			pix_s3 <= pix_s2;
			div_s3 <= div_pair(div_s2, 3'd7);
		end
		if (en_s4 && v_s3) begin
			pix_s4 <= pix_s3;
			div_s4 <= div_pair(div_s3, 3'd5);
		end
		if (en_s5 && v_s4) begin
			pix_s5 <= pix_s4;
			div_s5 <= div_pair(div_s4, 3'd3);
		end
		if (en_s6 && v_s5) begin
			out_s6 <= out_next;
		end
	end

	assign dst_valid = v_s6;
	assign dst_data  = out_s6;

endmodule

// File: src/amlc_checker.sv
// Port-level checker of the alpha-mask levels compositor and its bind.
`include "alpha_mask_levels_compositor_macros.svh"

module amlc_checker
	import amlc_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     src_stall,
	input logic     dst_valid,
	input logic     dst_stall,
	input pix_out_t dst_data
);

	// A stalled result request stays up and keeps its payload.
	`AMLC_ASSERT_NEXT(a_dst_hold, dst_valid && dst_stall, dst_valid && $stable(dst_data), "dst request changed while stalled")

	// With no result waiting the pipeline has room, so the source is never held.
	`AMLC_ASSERT_NOW(a_empty_no_stall, !dst_valid, !src_stall, "src stalled with an empty output stage")

	// When the sink takes results every stage moves, so the source is never held.
	`AMLC_ASSERT_NOW(a_flow_no_stall, !dst_stall, !src_stall, "src stalled while dst is flowing")

endmodule

bind alpha_mask_levels_compositor amlc_checker u_amlc_checker (.*);

// File: tb/testbench.sv
// Self-checking testbench of the alpha-mask levels compositor, with its own pixel predictor.
`timescale 1ns / 100ps

module testbench;
	import amlc_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 200000;
	localparam int unsigned PHASE_PIXELS  = 98;
	localparam int unsigned RANDOM_PHASES = 8;
	localparam int unsigned HOLD_AFTER    = 300;
	localparam int unsigned HOLD_CYCLES   = 120;
	localparam int unsigned DRAIN_CYCLES  = 12;
	localparam int unsigned REPORT_LIMIT  = 10;

	// First register index past the end of the register list.
	localparam logic [CFG_INDEX_W-1:0] REG_PAST_LAST = 3'd5;

	// Styles of back-pressure applied by the receiving side.
	typedef enum logic [1:0] {
		FLOW_FREE,
		FLOW_LIGHT,
		FLOW_HEAVY,
		FLOW_TOGGLE
	} flow_style_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_wen   = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;
	logic                   src_valid = 1'b0;
	logic                   src_stall;
	pix_in_t                src_data  = '0;
	logic                   dst_valid;
	logic                   dst_stall = 1'b0;
	pix_out_t               dst_data;

	// Pixels waiting to be offered, and results predicted for accepted pixels.
	pix_in_t     pending_pixels[$];
	pix_out_t    expected_pixels[$];
	cfg_t        levels_cfg;
	int unsigned mismatches   = 0;
	int unsigned results_seen = 0;
	int unsigned cycle_count  = 0;

	alpha_mask_levels_compositor uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src_data (src_data),
		.dst_valid(dst_valid),
		.dst_stall(dst_stall),
		.dst_data (dst_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Expected output pixel for one input pixel under a given register set.
	function automatic pix_out_t predict_pixel(input pix_in_t px, input cfg_t c);
		pix_out_t    res;
		int unsigned mask;
		int unsigned lo;
		int unsigned hi;
		int unsigned span;
		if (c.alpha_source) begin
			mask = 32'(px.aux_blue);
		end else begin
			mask = ((px.aux_blue | px.aux_green | px.aux_red) != 8'd0) ? 255 : 0;
		end
		// Levels remap with the white point kept above the black point.
		if (!c.skip_levels) begin
			lo = 32'(c.levels_black);
			hi = 32'(c.levels_white);
			if (hi < lo + 1) begin
				hi = lo + 1;
			end
			if (mask <= lo) begin
				mask = 0;
			end else if (mask >= hi) begin
				mask = 255;
			end else begin
				span = hi - lo;
				mask = (510 * (mask - lo) + span) / (2 * span);
			end
		end
		res.out_blue  = px.main_blue;
		res.out_green = px.main_green;
		res.out_red   = px.main_red;
		res.out_alpha = px.main_alpha;
		case (c.output_mode)
			MODE_MERGE: begin
				res.out_alpha = mask[7:0];
			end
			MODE_MASK: begin
				res.out_blue  = mask[7:0];
				res.out_green = mask[7:0];
				res.out_red   = mask[7:0];
				res.out_alpha = BYTE_MAX;
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	function automatic pix_in_t make_pixel(input logic [7:0] mb, input logic [7:0] mg,
			input logic [7:0] mr, input logic [7:0] ma, input logic [7:0] ab,
			input logic [7:0] ag, input logic [7:0] ar);
		pix_in_t px;
		px.main_blue  = mb;
		px.main_green = mg;
		px.main_red   = mr;
		px.main_alpha = ma;
		px.aux_blue   = ab;
		px.aux_green  = ag;
		px.aux_red    = ar;
		return px;
	endfunction

	// Random pixel, with the mask byte often placed near the black and white points.
	function automatic pix_in_t random_pixel();
		pix_in_t     px;
		logic [63:0] bits;
		int          near;
		int          white_eff;
		bits = {$urandom, $urandom};
		px = bits[55:0];
		white_eff = (levels_cfg.levels_white > levels_cfg.levels_black) ?
			int'(levels_cfg.levels_white) : int'(levels_cfg.levels_black) + 1;
		near = -1;
		case ($urandom_range(0, 5))
			0: near = int'(levels_cfg.levels_black) + $urandom_range(0, 4) - 2;
			1: near = white_eff + $urandom_range(0, 4) - 2;
			2: begin
				px.aux_blue  = 8'd0;
				px.aux_green = 8'd0;
				px.aux_red   = 8'd0;
			end
			default: begin
			end
		endcase
		if (near >= 0 && near <= 255) begin
			px.aux_blue = near[7:0];
		end
		return px;
	endfunction

	// One register write; the predictor copy keeps the bits that the register holds.
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_wen <= 1'b0;
		case (idx)
			REG_ALPHA_SOURCE: levels_cfg.alpha_source = val[0];
			REG_SKIP_LEVELS:  levels_cfg.skip_levels  = val[0];
			REG_OUTPUT_MODE:  levels_cfg.output_mode  = out_mode_t'(val[1:0]);
			REG_LEVELS_BLACK: levels_cfg.levels_black = val[7:0];
			REG_LEVELS_WHITE: levels_cfg.levels_white = val[7:0];
			default: begin
			end
		endcase
	endtask

	task automatic configure(input logic [7:0] source, input logic [7:0] skip,
			input logic [7:0] mode, input logic [7:0] black, input logic [7:0] white);
		write_reg(REG_ALPHA_SOURCE, source);
		write_reg(REG_SKIP_LEVELS, skip);
		write_reg(REG_OUTPUT_MODE, mode);
		write_reg(REG_LEVELS_BLACK, black);
		write_reg(REG_LEVELS_WHITE, white);
	endtask

	// Wait until every queued request has been accepted and every result has arrived.
	task automatic drain();
		while (pending_pixels.size() != 0 || expected_pixels.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic report_mismatch(input string what, input pix_out_t want, input pix_out_t got);
		mismatches++;
		if (mismatches <= REPORT_LIMIT) begin
			$display("mismatch (%s) at result %0d: expected B%h G%h R%h A%h, got B%h G%h R%h A%h",
				what, results_seen, want.out_blue, want.out_green, want.out_red,
				want.out_alpha, got.out_blue, got.out_green, got.out_red, got.out_alpha);
		end
	endtask

	// Sender: bursts of requests with random gaps; a stalled request is held unchanged.
	int unsigned burst_left;
	int unsigned gap_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_valid <= 1'b0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			if (src_valid && !src_stall) begin
				expected_pixels.push_back(predict_pixel(src_data, levels_cfg));
				void'(pending_pixels.pop_front());
			end
			if (src_valid && src_stall) begin
				// Hold the current request.
			end else if (gap_left != 0) begin
				gap_left--;
				src_valid <= 1'b0;
			end else if (pending_pixels.size() != 0) begin
				src_valid <= 1'b1;
				src_data  <= pending_pixels[0];
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 24);
				end
				burst_left--;
				if (burst_left == 0) begin
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				src_valid <= 1'b0;
			end
		end
	end

	// Receiver: changing stall styles, and one long hold that fills the pipeline.
	flow_style_t flow_style;
	int unsigned style_left;
	int unsigned hold_left;
	bit          hold_done;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_stall <= 1'b0;
			flow_style = FLOW_FREE;
			style_left = 0;
			hold_left  = 0;
			hold_done  = 1'b0;
		end else begin
			if (!hold_done && results_seen >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				dst_stall <= 1'b1;
			end else begin
				if (style_left == 0) begin
					flow_style = flow_style_t'($urandom_range(0, 3));
					style_left = $urandom_range(16, 80);
				end
				style_left--;
				case (flow_style)
					FLOW_FREE:  dst_stall <= 1'b0;
					FLOW_LIGHT: dst_stall <= ($urandom_range(0, 3) == 0);
					FLOW_HEAVY: dst_stall <= ($urandom_range(0, 3) != 0);
					default:    dst_stall <= ~dst_stall;
				endcase
			end
		end
	end

	// Monitor: each accepted result is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && dst_valid && !dst_stall) begin
			if (expected_pixels.size() == 0) begin
				report_mismatch("no request outstanding", '0, dst_data);
			end else if (dst_data !== expected_pixels[0]) begin
				report_mismatch("wrong pixel", expected_pixels[0], dst_data);
				void'(expected_pixels.pop_front());
			end else begin
				void'(expected_pixels.pop_front());
			end
			results_seen++;
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[alpha_mask_levels_compositor] ERROR");
			$finish;
		end
	end

	initial begin
		levels_cfg.alpha_source = RST_ALPHA_SOURCE;
		levels_cfg.skip_levels  = RST_SKIP_LEVELS;
		levels_cfg.output_mode  = RST_OUTPUT_MODE;
		levels_cfg.levels_black = RST_LEVELS_BLACK;
		levels_cfg.levels_white = RST_LEVELS_WHITE;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: binary mask from the auxiliary pixel, merged into alpha.
		pending_pixels.push_back(make_pixel(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		pending_pixels.push_back(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
		pending_pixels.push_back(make_pixel(8'h12, 8'h34, 8'h56, 8'h78, 8'h00, 8'h00, 8'h01));
		pending_pixels.push_back(make_pixel(8'hA5, 8'h5A, 8'hC3, 8'h3C, 8'h00, 8'h80, 8'h00));
		pending_pixels.push_back(make_pixel(8'h01, 8'h80, 8'hFE, 8'h7F, 8'h01, 8'h00, 8'h00));
		drain();

		// Grey mask output across the remap: at and around both points.
		configure(8'd1, 8'd0, 8'(MODE_MASK), 8'd100, 8'd200);
		pending_pixels.push_back(make_pixel(8'h11, 8'h22, 8'h33, 8'h44, 8'd0, 8'hFF, 8'hFF));
		pending_pixels.push_back(make_pixel(8'h11, 8'h22, 8'h33, 8'h44, 8'd100, 8'h00, 8'h00));
		pending_pixels.push_back(make_pixel(8'h11, 8'h22, 8'h33, 8'h44, 8'd101, 8'h00, 8'h00));
		pending_pixels.push_back(make_pixel(8'h11, 8'h22, 8'h33, 8'h44, 8'd150, 8'h00, 8'h00));
		pending_pixels.push_back(make_pixel(8'h11, 8'h22, 8'h33, 8'h44, 8'd199, 8'h00, 8'h00));
		pending_pixels.push_back(make_pixel(8'h11, 8'h22, 8'h33, 8'h44, 8'd200, 8'h00, 8'h00));
		pending_pixels.push_back(make_pixel(8'h11, 8'h22, 8'h33, 8'h44, 8'd255, 8'h00, 8'h00));
		drain();

		// Black point at full scale: every mask value maps to zero.
		configure(8'd1, 8'd0, 8'(MODE_MERGE), 8'd255, 8'd3);
		pending_pixels.push_back(make_pixel(8'h01, 8'h02, 8'h03, 8'h04, 8'd0, 8'h00, 8'h00));
		pending_pixels.push_back(make_pixel(8'h01, 8'h02, 8'h03, 8'h04, 8'd254, 8'h00, 8'h00));
		pending_pixels.push_back(make_pixel(8'h01, 8'h02, 8'h03, 8'h04, 8'd255, 8'h00, 8'h00));
		drain();

		// White point equal to black: it is raised by one.
		write_reg(REG_LEVELS_BLACK, 8'd50);
		write_reg(REG_LEVELS_WHITE, 8'd50);
		pending_pixels.push_back(make_pixel(8'h0F, 8'hF0, 8'h55, 8'hAA, 8'd49, 8'h00, 8'h00));
		pending_pixels.push_back(make_pixel(8'h0F, 8'hF0, 8'h55, 8'hAA, 8'd50, 8'h00, 8'h00));
		pending_pixels.push_back(make_pixel(8'h0F, 8'hF0, 8'h55, 8'hAA, 8'd51, 8'h00, 8'h00));
		drain();

		// Raw mask without the remap, shown as a grey pixel.
		write_reg(REG_SKIP_LEVELS, 8'd1);
		write_reg(REG_OUTPUT_MODE, 8'(MODE_MASK));
		pending_pixels.push_back(make_pixel(8'h9C, 8'h63, 8'h00, 8'hFF, 8'h7F, 8'hFF, 8'h00));
		drain();

		// Wide writes keep only the register's low bits; the unused mode passes through.
		// Writes past the last register must leave the settings alone.
		configure(8'hFE, 8'hFF, 8'hFF, 8'h80, 8'h81);
		for (int idx = int'(REG_PAST_LAST); idx < (1 << CFG_INDEX_W); idx++) begin
			write_reg(idx[CFG_INDEX_W-1:0], 8'hFF);
		end
		pending_pixels.push_back(make_pixel(8'hC0, 8'hDE, 8'hBA, 8'h5E, 8'h00, 8'h00, 8'h00));
		pending_pixels.push_back(make_pixel(8'h3F, 8'h21, 8'h45, 8'hA1, 8'hFF, 8'h10, 8'h01));
		drain();

		// Random phases, starting with the extreme settings.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0: configure(8'd1, 8'd0, 8'(MODE_MERGE), 8'd0, 8'd255);
				1: configure(8'd1, 8'd0, 8'(MODE_MASK), 8'd254, 8'd255);
				2: configure(8'd0, 8'd0, 8'(MODE_MASK), 8'd0, 8'd1);
				3: configure(8'd1, 8'd1, 8'(MODE_MERGE), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)));
				4: configure(8'd0, 8'd1, 8'(MODE_PASS), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)));
				default: configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)));
			endcase
			for (int n = 0; n < PHASE_PIXELS; n++) begin
				pending_pixels.push_back(random_pixel());
			end
			drain();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_pixels.size() == 0) begin
			$display("[alpha_mask_levels_compositor] OK");
		end else begin
			$display("[alpha_mask_levels_compositor] ERROR");
		end
		$finish;
	end

endmodule
